/* rtl/core/tlptw_pkg.sv */
// Shared definitions for the two-level page table walker.
// Holds request codes, field widths and entry bit positions.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tlptw_pkg;

  localparam int OP_W    = 2;
  localparam int VA_W    = 32;
  localparam int PA_W    = 32;
  localparam int FLAGS_W = 3;
  localparam int IDX_W   = 10;
  localparam int OFS_W   = 12;
  localparam int FRAME_W = 20;
  localparam int PTE_W   = 24;

  localparam int DIR_SLOTS = 1 << IDX_W;

  localparam int PTE_P_BIT  = 0;
  localparam int PTE_W_BIT  = 1;
  localparam int PTE_U_BIT  = 2;
  localparam int PTE_NC_BIT = 3;
  localparam int PTE_FRAME_LSB = 4;

  localparam int FLAG_WRITE = 0;
  localparam int FLAG_USER  = 1;
  localparam int FLAG_NC    = 2;

  typedef enum logic [OP_W-1:0] {
    OP_MAP   = 2'd0,
    OP_UNMAP = 2'd1,
    OP_XLATE = 2'd2
  } op_t;

endpackage

`default_nettype wire

/* rtl/core/tlptw_ram.sv */
// Simple dual-port synchronous RAM with one write port and one registered read port.
// Used for the page directory and for the second-level table pool.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module tlptw_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* rtl/core/two_level_page_table_walker_core.sv */
// Top level of the two-level page table walker: sequencer, allocator and both stores.
// Depends on tlptw_pkg and tlptw_ram.
// The result strobe is set on leaving S_DIR for a map, a directory miss or an unknown code,
// and on leaving S_TBL for an unmap or translate that reaches a table, which waits on
// the dependent directory read and table read.
// A new request is taken only in S_IDLE, one at a time; the next request may start on the done cycle.
// Reset: a clearing pass over every table entry and every directory slot, with busy held high.
`timescale 1ns / 1ps
`default_nettype none

module two_level_page_table_walker_core #(
  parameter int NUM_TABLES = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [tlptw_pkg::OP_W-1:0]          operation,
  input  logic [tlptw_pkg::VA_W-1:0]          virt_addr,
  input  logic [tlptw_pkg::PA_W-1:0]          phys_addr,
  input  logic [tlptw_pkg::FLAGS_W-1:0]       access_flags,
  output logic                                done,
  output logic                                status,
  output logic [tlptw_pkg::VA_W-1:0]          translated_addr,
  output logic                                was_mapped,
  output logic                                flush_request
);

  import tlptw_pkg::*;

  localparam int TW        = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
  localparam int FW        = $clog2(NUM_TABLES + 1);
  localparam int DW        = TW + 1;
  localparam int TAW       = TW + IDX_W;
  localparam int TBL_DEPTH = NUM_TABLES * DIR_SLOTS;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_DIR,
    S_TBL
  } state_t;

  state_t state;

  logic [OP_W-1:0]    op_q;
  logic [VA_W-1:0]    va_q;
  logic [PA_W-1:0]    pa_q;
  logic [FLAGS_W-1:0] flags_q;
  logic [TAW-1:0]     clr_cnt;
  logic [FW-1:0]      next_free;
  logic [TAW-1:0]     tbl_addr_q;

  logic             dir_we;
  logic [IDX_W-1:0] dir_waddr;
  logic [DW-1:0]    dir_wdata;
  logic [DW-1:0]    dir_rdata;
  logic             tbl_we;
  logic [TAW-1:0]   tbl_waddr;
  logic [PTE_W-1:0] tbl_wdata;
  logic [TAW-1:0]   tbl_raddr;
  logic [PTE_W-1:0] tbl_rdata;

  logic             accept;
  logic             dir_hit;
  logic [TW-1:0]    pde_table;
  logic [IDX_W-1:0] dir_idx;
  logic [IDX_W-1:0] tbl_idx;
  logic             pool_free;
  logic [PTE_W-1:0] new_pte;

  assign busy        = (state != S_IDLE);
  assign accept      = start && !busy;
  assign dir_hit     = dir_rdata[TW];
  assign pde_table   = dir_rdata[TW-1:0];
  assign dir_idx     = va_q[VA_W-1 -: IDX_W];
  assign tbl_idx     = va_q[OFS_W +: IDX_W];
  assign pool_free   = (next_free < FW'(NUM_TABLES));

  always_comb begin
    new_pte                = '0;
    new_pte[PTE_W-1 -: FRAME_W] = pa_q[PA_W-1 -: FRAME_W];
    new_pte[PTE_P_BIT]     = 1'b1;
    new_pte[PTE_W_BIT]     = flags_q[FLAG_WRITE];
    new_pte[PTE_U_BIT]     = flags_q[FLAG_USER];
    new_pte[PTE_NC_BIT]    = flags_q[FLAG_NC];
  end

  always_comb begin
    dir_we    = 1'b0;
    dir_waddr = dir_idx;
    dir_wdata = {1'b1, next_free[TW-1:0]};
    tbl_we    = 1'b0;
    tbl_waddr = {pde_table, tbl_idx};
    tbl_wdata = new_pte;
    tbl_raddr = {pde_table, tbl_idx};
    unique case (state)
      S_CLEAR: begin
        dir_we    = (clr_cnt[TAW-1:IDX_W] == '0);
        dir_waddr = clr_cnt[IDX_W-1:0];
        dir_wdata = '0;
        tbl_we    = 1'b1;
        tbl_waddr = clr_cnt;
        tbl_wdata = '0;
      end
      S_DIR: begin
        if (op_q == OP_MAP) begin
          if (dir_hit) begin
            tbl_we = 1'b1;
          end else if (pool_free) begin
            dir_we    = 1'b1;
            tbl_we    = 1'b1;
            tbl_waddr = {next_free[TW-1:0], tbl_idx};
          end
        end
      end
      S_TBL: begin
        tbl_waddr = tbl_addr_q;
        tbl_wdata = '0;
        tbl_we    = (op_q == OP_UNMAP) && tbl_rdata[PTE_P_BIT];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      next_free <= '0;
      done      <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == TAW'(TBL_DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            op_q    <= operation;
            va_q    <= virt_addr;
            pa_q    <= phys_addr;
            flags_q <= access_flags;
            state   <= S_DIR;
          end
        end
        S_DIR: begin
          tbl_addr_q      <= {pde_table, tbl_idx};
          status          <= 1'b0;
          translated_addr <= '0;
          was_mapped      <= 1'b0;
          flush_request   <= 1'b0;
          done            <= 1'b1;
          state           <= S_IDLE;
          unique case (op_q)
            OP_MAP: begin
              if (dir_hit) begin
                flush_request <= 1'b1;
              end else if (pool_free) begin
                flush_request <= 1'b1;
                next_free     <= next_free + 1'b1;
              end else begin
                status <= 1'b1;
              end
            end
            OP_UNMAP, OP_XLATE: begin
              if (dir_hit) begin
                done  <= 1'b0;
                state <= S_TBL;
              end
            end
            default: begin
            end
          endcase
        end
        S_TBL: begin
          status          <= 1'b0;
          translated_addr <= '0;
          was_mapped      <= 1'b0;
          flush_request   <= 1'b0;
          if (tbl_rdata[PTE_P_BIT]) begin
            was_mapped <= 1'b1;
            if (op_q == OP_UNMAP) begin
              flush_request <= 1'b1;
            end else begin
              translated_addr <= {tbl_rdata[PTE_W-1 -: FRAME_W], va_q[OFS_W-1:0]};
            end
          end
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  tlptw_ram #(
    .DEPTH (DIR_SLOTS),
    .AW    (IDX_W),
    .DW    (DW)
  ) u_dir_ram (
    .clk   (clk),
    .we    (dir_we),
    .waddr (dir_waddr),
    .wdata (dir_wdata),
    .raddr (virt_addr[VA_W-1 -: IDX_W]),
    .rdata (dir_rdata)
  );

  tlptw_ram #(
    .DEPTH (TBL_DEPTH),
    .AW    (TAW),
    .DW    (PTE_W)
  ) u_tbl_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  a_exhausted_quiet: assert property (@(posedge clk) disable iff (rst)
    done && status |-> translated_addr == '0 && !was_mapped && !flush_request)
    else $error("Pool exhaustion result carries other fields.");

  a_mapped_not_failed: assert property (@(posedge clk) disable iff (rst)
    done && was_mapped |-> !status)
    else $error("A present entry was reported together with a failure.");

  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> !done)
    else $error("Result strobe one cycle after a request.");

  a_pool_bound: assert property (@(posedge clk) disable iff (rst)
    next_free <= FW'(NUM_TABLES))
    else $error("Table allocator ran past the pool.");

  a_done_follows_work: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_DIR || state == S_TBL))
    else $error("Result strobe without a request in progress.");

endmodule

`default_nettype wire
